// File: src/dq_pkg.sv
// Shared constants, types and index helpers of the double-ended queue.
`default_nettype none
package dq_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int CMD_W      = 3;
  localparam int WORD_W     = 32;
  localparam int COUNT_W    = 5;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK       = 3'd4
  } command_t;

  typedef enum logic {
    ST_IDLE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  function automatic idx_t idx_next(input idx_t i);
    idx_t r;
    if (i == idx_t'(CAPACITY - 1)) begin
      r = '0;
    end else begin
      r = i + idx_t'(1);
    end
    return r;
  endfunction

  function automatic idx_t idx_prev(input idx_t i);
    idx_t r;
    if (i == '0) begin
      r = idx_t'(CAPACITY - 1);
    end else begin
      r = i - idx_t'(1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/dq_intf.sv
// Handshake interfaces for the command channel and the result channel.
`default_nettype none
interface dq_in_if
  import dq_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [WORD_W-1:0] push_value;

  modport source (output valid, output command, output push_value, input ready);
  modport sink (input valid, input command, input push_value, output ready);
endinterface

interface dq_out_if
  import dq_pkg::*;
  ;
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  popped_value;
  logic [WORD_W-1:0]  front_value;
  logic [WORD_W-1:0]  back_value;
  logic               is_empty;
  logic [COUNT_W-1:0] entry_count;
  logic               error_flag;

  modport source (output valid, output popped_value, output front_value,
                  output back_value, output is_empty, output entry_count,
                  output error_flag, input ready);
  modport sink (input valid, input popped_value, input front_value,
                input back_value, input is_empty, input entry_count,
                input error_flag, output ready);
endinterface
`default_nettype wire

// File: src/dq_ctrl.sv
// Controller state machine that sequences each queue transaction.
`default_nettype none
module dq_ctrl
  import dq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd_o.accept = 1'b0;
    cmd_o.finish = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd_o.accept = in_valid;
      end
      ST_FINISH: begin
        cmd_o.finish = status_i.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: src/dq_datapath.sv
// Datapath with the circular store, the pointers, the end caches and the result register.
`default_nettype none
module dq_datapath
  import dq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ctrl_cmd_t         cmd_i,
  output dp_status_t             status_o,
  input  wire logic [CMD_W-1:0]  in_command,
  input  wire logic [WORD_W-1:0] in_push_value,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [WORD_W-1:0]      out_popped_value,
  output logic [WORD_W-1:0]      out_front_value,
  output logic [WORD_W-1:0]      out_back_value,
  output logic                   out_is_empty,
  output logic [COUNT_W-1:0]     out_entry_count,
  output logic                   out_error_flag
);

  data_t mem [CAPACITY];

  idx_t  front_idx_r, front_idx_nxt;
  idx_t  back_idx_r, back_idx_nxt;
  cnt_t  count_r, count_nxt;
  data_t front_val_r, front_val_nxt;
  data_t back_val_r, back_val_nxt;
  data_t popped_r, popped_nxt;
  logic  err_r, err_nxt;
  logic  refill_front_r, refill_front_nxt;
  logic  refill_back_r, refill_back_nxt;
  data_t rdata_r;
  logic  out_valid_r;

  logic     mem_we;
  logic     mem_re;
  idx_t     waddr;
  idx_t     raddr;
  data_t    word;
  data_t    front_sel;
  data_t    back_sel;
  logic     is_full;
  logic     is_empty;
  command_t cmd;

  assign word      = DATA_WIDTH'(in_push_value);
  assign cmd       = command_t'(in_command);
  assign is_full   = (count_r == cnt_t'(CAPACITY));
  assign is_empty  = (count_r == '0);
  assign front_sel = refill_front_r ? rdata_r : front_val_r;
  assign back_sel  = refill_back_r ? rdata_r : back_val_r;

  assign status_o.out_free = !out_valid_r || out_ready;
  assign out_valid         = out_valid_r;

  always_comb begin
    front_idx_nxt    = front_idx_r;
    back_idx_nxt     = back_idx_r;
    count_nxt        = count_r;
    front_val_nxt    = front_val_r;
    back_val_nxt     = back_val_r;
    popped_nxt       = popped_r;
    err_nxt          = err_r;
    refill_front_nxt = refill_front_r;
    refill_back_nxt  = refill_back_r;
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    waddr            = idx_prev(front_idx_r);
    raddr            = idx_next(front_idx_r);
    if (cmd_i.accept) begin
      popped_nxt       = '0;
      err_nxt          = 1'b0;
      refill_front_nxt = 1'b0;
      refill_back_nxt  = 1'b0;
      unique case (cmd)
        CMD_PUSH_FRONT: begin
          if (is_full) begin
            err_nxt = 1'b1;
          end else begin
            front_idx_nxt = idx_prev(front_idx_r);
            mem_we        = 1'b1;
            waddr         = idx_prev(front_idx_r);
            front_val_nxt = word;
            if (is_empty) begin
              back_val_nxt = word;
            end
            count_nxt = count_r + cnt_t'(1);
          end
        end
        CMD_PUSH_BACK: begin
          if (is_full) begin
            err_nxt = 1'b1;
          end else begin
            back_idx_nxt = idx_next(back_idx_r);
            mem_we       = 1'b1;
            waddr        = idx_next(back_idx_r);
            back_val_nxt = word;
            if (is_empty) begin
              front_val_nxt = word;
            end
            count_nxt = count_r + cnt_t'(1);
          end
        end
        CMD_POP_FRONT: begin
          if (is_empty) begin
            err_nxt = 1'b1;
          end else begin
            popped_nxt       = front_val_r;
            front_idx_nxt    = idx_next(front_idx_r);
            count_nxt        = count_r - cnt_t'(1);
            mem_re           = 1'b1;
            raddr            = idx_next(front_idx_r);
            refill_front_nxt = 1'b1;
          end
        end
        CMD_POP_BACK: begin
          if (is_empty) begin
            err_nxt = 1'b1;
          end else begin
            popped_nxt      = back_val_r;
            back_idx_nxt    = idx_prev(back_idx_r);
            count_nxt       = count_r - cnt_t'(1);
            mem_re          = 1'b1;
            raddr           = idx_prev(back_idx_r);
            refill_back_nxt = 1'b1;
          end
        end
        default: begin
          err_nxt = 1'b0;
        end
      endcase
    end
    if (cmd_i.finish) begin
      front_val_nxt = front_sel;
      back_val_nxt  = back_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= word;
    end
    if (mem_re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_idx_r    <= '0;
      back_idx_r     <= idx_t'(CAPACITY - 1);
      count_r        <= '0;
      refill_front_r <= 1'b0;
      refill_back_r  <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      front_idx_r    <= front_idx_nxt;
      back_idx_r     <= back_idx_nxt;
      count_r        <= count_nxt;
      refill_front_r <= refill_front_nxt;
      refill_back_r  <= refill_back_nxt;
      if (cmd_i.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    front_val_r <= front_val_nxt;
    back_val_r  <= back_val_nxt;
    popped_r    <= popped_nxt;
    err_r       <= err_nxt;
    if (cmd_i.finish) begin
      out_popped_value <= WORD_W'(popped_r);
      out_front_value  <= is_empty ? '0 : WORD_W'(front_sel);
      out_back_value   <= is_empty ? '0 : WORD_W'(back_sel);
      out_is_empty     <= is_empty;
      out_entry_count  <= COUNT_W'(count_r);
      out_error_flag   <= err_r;
    end
  end

endmodule
`default_nettype wire

// File: src/double_ended_queue.sv
// Top level of the bounded double-ended queue.
// The queue holds up to CAPACITY words in a circular store with one write port and one
// registered read port, and caches the words at both ends in registers. Each command
// transaction has an accept step, which updates the pointers and writes or reads the
// store, then a finish step, which forms the result from the end caches and read data.
// A new command is taken once the previous result has been loaded into the output
// register, and the finish step waits until that register is free. Pops from an empty
// queue and pushes into a full one leave the queue unchanged and set the error flag;
// command codes above four act as a peek.
`default_nettype none
module double_ended_queue
  import dq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  dq_in_if.sink     in_if,
  dq_out_if.source  out_if
);

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  dq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .status_i (dp_status),
    .cmd_o    (ctrl_cmd)
  );

  dq_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_i            (ctrl_cmd),
    .status_o         (dp_status),
    .in_command       (in_if.command),
    .in_push_value    (in_if.push_value),
    .out_ready        (out_if.ready),
    .out_valid        (out_if.valid),
    .out_popped_value (out_if.popped_value),
    .out_front_value  (out_if.front_value),
    .out_back_value   (out_if.back_value),
    .out_is_empty     (out_if.is_empty),
    .out_entry_count  (out_if.entry_count),
    .out_error_flag   (out_if.error_flag)
  );

endmodule
`default_nettype wire

// File: tb/deque_check.sv
// Checker that predicts every deque result from the accepted commands and compares it field by field.
`default_nettype none
module deque_check
  import dq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  dq_in_if          cmd_bus,
  dq_out_if         res_bus,
  output int        error_count,
  output int        pending_results
);

  typedef struct packed {
    logic [WORD_W-1:0]  popped_value;
    logic [WORD_W-1:0]  front_value;
    logic [WORD_W-1:0]  back_value;
    logic               is_empty;
    logic [COUNT_W-1:0] entry_count;
    logic               error_flag;
  } deque_result_t;

  data_t         shadow_words [CAPACITY];
  int            head_pos = 0;
  int            tail_pos = CAPACITY - 1;
  int            held_count = 0;
  deque_result_t expected_results [$];
  deque_result_t observed;
  deque_result_t wanted;

  function automatic deque_result_t apply_command(input logic [CMD_W-1:0] code,
                                                  input logic [WORD_W-1:0] word);
    deque_result_t r;
    r = '0;
    case (code)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (held_count >= CAPACITY) begin
          r.error_flag = 1'b1;
        end else if (code == CMD_PUSH_FRONT) begin
          head_pos = (head_pos + CAPACITY - 1) % CAPACITY;
          shadow_words[head_pos] = data_t'(word);
          held_count++;
        end else begin
          tail_pos = (tail_pos + 1) % CAPACITY;
          shadow_words[tail_pos] = data_t'(word);
          held_count++;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (held_count == 0) begin
          r.error_flag = 1'b1;
        end else if (code == CMD_POP_FRONT) begin
          r.popped_value = WORD_W'(shadow_words[head_pos]);
          head_pos = (head_pos + 1) % CAPACITY;
          held_count--;
        end else begin
          r.popped_value = WORD_W'(shadow_words[tail_pos]);
          tail_pos = (tail_pos + CAPACITY - 1) % CAPACITY;
          held_count--;
        end
      end
      default: begin
      end
    endcase
    if (held_count == 0) begin
      r.is_empty = 1'b1;
    end else begin
      r.front_value = WORD_W'(shadow_words[head_pos]);
      r.back_value  = WORD_W'(shadow_words[tail_pos]);
    end
    r.entry_count = COUNT_W'(held_count);
    return r;
  endfunction

  task automatic check_field(input string field, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      error_count     = 0;
      pending_results = 0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        observed = '{res_bus.popped_value, res_bus.front_value, res_bus.back_value,
                     res_bus.is_empty, res_bus.entry_count, res_bus.error_flag};
        if (expected_results.size() == 0) begin
          $error("Result transaction arrived with no command outstanding.");
          error_count++;
        end else begin
          wanted = expected_results.pop_front();
          check_field("popped_value", wanted.popped_value, observed.popped_value);
          check_field("front_value", wanted.front_value, observed.front_value);
          check_field("back_value", wanted.back_value, observed.back_value);
          check_field("is_empty", WORD_W'(wanted.is_empty), WORD_W'(observed.is_empty));
          check_field("entry_count", WORD_W'(wanted.entry_count),
                      WORD_W'(observed.entry_count));
          check_field("error_flag", WORD_W'(wanted.error_flag),
                      WORD_W'(observed.error_flag));
        end
      end
      if (cmd_bus.valid && cmd_bus.ready) begin
        expected_results.push_back(apply_command(cmd_bus.command, cmd_bus.push_value));
      end
      pending_results = expected_results.size();
    end
  end

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Top of the deque testbench: clock, reset, command and result traffic, watchdog and verdict.
`default_nettype none
module tb_top;
  import dq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RESERVED_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RESERVED_MID   = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RESERVED_LAST  = 3'd7;
  localparam int RANDOM_COMMANDS = 1100;
  localparam int STALL_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 10;

  logic clk = 1'b0;
  logic rst_n;
  int   error_count;
  int   pending_results;
  int   idle_cycles = 0;
  logic send_steady = 1'b1;
  logic recv_steady = 1'b1;

  dq_in_if  in_ch ();
  dq_out_if out_ch ();

  double_ended_queue dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  deque_check u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_bus         (in_ch),
    .res_bus         (out_ch),
    .error_count     (error_count),
    .pending_results (pending_results)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic send_command(input logic [CMD_W-1:0] code, input logic [WORD_W-1:0] word);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.command    <= code;
    in_ch.push_value <= word;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_results;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  function automatic logic [WORD_W-1:0] draw_word;
    logic [WORD_W-1:0] w;
    int                bit_pos;
    bit_pos = $urandom_range(0, WORD_W - 1);
    case ($urandom_range(0, 9))
      0:       w = '0;
      1:       w = '1;
      2:       w = WORD_W'(1) << bit_pos;
      3:       w = ~(WORD_W'(1) << bit_pos);
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic logic [CMD_W-1:0] draw_command(input int push_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      return CMD_W'($urandom_range(CMD_RESERVED_FIRST, CMD_RESERVED_LAST));
    end else if (roll < 8) begin
      return CMD_PEEK;
    end else if ($urandom_range(0, 99) < push_pct) begin
      return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
    end
    return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int gap;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = recv_steady ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    int sent;
    int phase_len;
    int push_pct;
    int phase_count;
    in_ch.valid      = 1'b0;
    in_ch.command    = '0;
    in_ch.push_value = '0;
    rst_n            = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_command(CMD_POP_FRONT, 32'h1234_5678);
    send_command(CMD_POP_BACK, 32'hFFFF_FFFF);
    send_command(CMD_PEEK, 32'hDEAD_BEEF);
    send_command(CMD_RESERVED_FIRST, 32'hFFFF_FFFF);
    send_command(CMD_RESERVED_MID, 32'h0);
    send_command(CMD_RESERVED_LAST, 32'hA5A5_5A5A);
    send_command(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    send_command(CMD_PUSH_BACK, 32'h0000_0000);
    send_command(CMD_PEEK, 32'h0);
    send_command(CMD_PUSH_FRONT, 32'h8000_0001);
    send_command(CMD_PUSH_BACK, 32'h7FFF_FFFE);
    send_command(CMD_POP_BACK, 32'h0);
    send_command(CMD_POP_FRONT, 32'h0);
    send_command(CMD_POP_FRONT, 32'h0);
    send_command(CMD_POP_BACK, 32'h0);
    send_command(CMD_POP_BACK, 32'h0);
    send_command(CMD_PUSH_BACK, 32'h5555_AAAA);
    send_command(CMD_POP_FRONT, 32'h0);
    drain_results();

    sent        = 0;
    phase_count = 0;
    while (sent < RANDOM_COMMANDS) begin
      phase_len   = $urandom_range(40, 120);
      send_steady = ($urandom_range(0, 3) == 0);
      recv_steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      repeat (phase_len) begin
        send_command(draw_command(push_pct), draw_word());
        sent++;
      end
      phase_count++;
      if (phase_count == 1 || $urandom_range(0, 3) == 0) begin
        drain_results();
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
src/dq_pkg.sv
src/dq_intf.sv
src/dq_ctrl.sv
src/dq_datapath.sv
src/double_ended_queue.sv
tb/deque_check.sv
tb/tb_top.sv
